// ===== sv/zcdp_pkg.sv =====
// Shared types, constants and hash helper for the ZIP central directory parser.
package zcdp_pkg;

	// Fixed entry header layout
	localparam int unsigned HEADER_BYTES = 46;
	localparam int unsigned POS_W        = 6;
	localparam int unsigned SKIP_W       = 18;
	localparam int unsigned EXTRA_W      = 17;

	localparam logic [31:0] CD_SIGNATURE = 32'h0201_4b50;
	localparam logic [63:0] FNV_BASIS    = 64'd14695981039346656037;
	localparam logic [63:0] FNV_PRIME    = 64'd1099511628211;
	localparam logic [15:0] LIMIT_RESET  = 16'd256;

	// Header byte positions at which a field is complete
	localparam logic [POS_W-1:0] POS_SIG      = 6'd3;
	localparam logic [POS_W-1:0] POS_METHOD   = 6'd11;
	localparam logic [POS_W-1:0] POS_PACKED   = 6'd23;
	localparam logic [POS_W-1:0] POS_UNPACKED = 6'd27;
	localparam logic [POS_W-1:0] POS_NAME_LEN = 6'd29;
	localparam logic [POS_W-1:0] POS_EXTRA    = 6'd31;
	localparam logic [POS_W-1:0] POS_COMMENT  = 6'd33;
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(HEADER_BYTES - 1);

	// Parse phase, one-hot
	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_NAME   = 3'b010,
		PH_SKIP   = 3'b100
	} phase_t;

	// Result record kinds
	typedef enum logic [1:0] {
		KIND_ENTRY = 2'd0,
		KIND_END   = 2'd1,
		KIND_TRUNC = 2'd2
	} kind_t;

	// One FNV-1a 64 step; the prime is 2^40 + 0x1b3, so the product is a shift-add
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

// ===== sv/zip_central_directory_parser.sv =====
// A record is registered and presented in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle while in_ready is high; the FNV step (constant shift-add) fits in that cycle.
// Input stalls only while a record waits in the output register and out_ready is low.
// Reset (arst_n low, asynchronous) returns the parser to the header phase, clears the
// output valid flag and sets the name limit to 256.
module zip_central_directory_parser import zcdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        name_limit_we,
	input  logic [15:0] name_limit,
	// byte stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	// records
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  record_kind,
	output logic [15:0] method,
	output logic [31:0] packed_size,
	output logic [31:0] unpacked_size,
	output logic [15:0] name_bytes,
	output logic [31:0] header_offset,
	output logic [63:0] name_digest,
	output logic        name_hashed
);

	// Parse state
	logic [15:0]        limit_q;
	logic [POS_W-1:0]   pos_q,     pos_d;
	phase_t             phase_q,   phase_d;
	logic [SKIP_W-1:0]  skip_q,    skip_d;
	logic [31:0]        shift_q,   shift_d;
	logic [15:0]        method_q,  method_d;
	logic [31:0]        packed_q,  packed_d;
	logic [31:0]        unpacked_q, unpacked_d;
	logic [15:0]        nlen_q,    nlen_d;
	logic [31:0]        offset_q,  offset_d;
	logic [EXTRA_W-1:0] extra_q,   extra_d;
	logic [63:0]        hash_q,    hash_d;
	logic               hash_en_q, hash_en_d;
	logic               stopped_q, stopped_d;

	// Step outcome
	logic               acc;
	logic               emit;
	kind_t              kind;
	logic               done;
	logic               bad;
	logic [15:0]        hi;
	logic               rec_hashed;

	// Output register
	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [15:0]        out_method_q;
	logic [31:0]        out_packed_q;
	logic [31:0]        out_unpacked_q;
	logic [15:0]        out_nlen_q;
	logic [31:0]        out_offset_q;
	logic [63:0]        out_digest_q;
	logic               out_hashed_q;

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;

	// Next state for one byte
	always_comb begin
		pos_d      = pos_q;
		phase_d    = phase_q;
		skip_d     = skip_q;
		shift_d    = shift_q;
		method_d   = method_q;
		packed_d   = packed_q;
		unpacked_d = unpacked_q;
		nlen_d     = nlen_q;
		offset_d   = offset_q;
		extra_d    = extra_q;
		hash_d     = hash_q;
		hash_en_d  = hash_en_q;
		stopped_d  = stopped_q;
		done       = 1'b0;
		bad        = 1'b0;
		hi         = 16'd0;

		if (!stopped_q) begin
			case (phase_q)
				PH_HEADER: begin
					shift_d = {data_byte, shift_q[31:8]};
					hi      = shift_d[31:16];
					case (pos_q)
						POS_SIG:      bad = (shift_d != CD_SIGNATURE);
						POS_METHOD:   method_d = hi;
						POS_PACKED:   packed_d = shift_d;
						POS_UNPACKED: unpacked_d = shift_d;
						POS_NAME_LEN: nlen_d = hi;
						POS_EXTRA:    extra_d = {1'b0, hi};
						POS_COMMENT:  extra_d = extra_q + {1'b0, hi};
						POS_LAST:     offset_d = shift_d;
						default:      ;
					endcase
					if (!bad && pos_q >= POS_LAST) begin
						// header complete: choose the next phase
						hash_en_d = (nlen_q < limit_q);
						hash_d    = FNV_BASIS;
						pos_d     = '0;
						if (nlen_q != 16'd0) begin
							phase_d = PH_NAME;
							skip_d  = {2'b00, nlen_q};
						end else if (extra_q != '0) begin
							phase_d = PH_SKIP;
							skip_d  = {1'b0, extra_q};
						end else begin
							done = 1'b1;
						end
					end else if (!bad) begin
						pos_d = pos_q + POS_W'(1);
					end
				end
				PH_NAME: begin
					if (hash_en_q) begin
						hash_d = fnv_step(hash_q, data_byte);
					end
					if (skip_q <= SKIP_W'(1)) begin
						skip_d = '0;
						if (extra_q != '0) begin
							phase_d = PH_SKIP;
							skip_d  = {1'b0, extra_q};
						end else begin
							done = 1'b1;
						end
					end else begin
						skip_d = skip_q - SKIP_W'(1);
					end
				end
				PH_SKIP: begin
					if (skip_q <= SKIP_W'(1)) begin
						skip_d = '0;
						done   = 1'b1;
					end else begin
						skip_d = skip_q - SKIP_W'(1);
					end
				end
				default: begin
					phase_d = PH_HEADER;
				end
			endcase
		end

		// Hash enable as it stands for this entry, including one decided on this byte
		rec_hashed = hash_en_d;

		// Record selection
		emit = !stopped_q && (done || bad || stream_end);
		if (done) begin
			kind = KIND_ENTRY;
		end else if (bad) begin
			kind = KIND_END;
		end else begin
			kind = KIND_TRUNC;
		end

		if (bad && !done) begin
			stopped_d = 1'b1;
		end

		// End of entry, bad signature or stream end: back to the header phase
		if (done || bad || stream_end) begin
			pos_d     = '0;
			phase_d   = PH_HEADER;
			skip_d    = '0;
			shift_d   = '0;
			extra_d   = '0;
			hash_en_d = 1'b0;
		end
		if (stream_end) begin
			stopped_d = 1'b0;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (name_limit_we) begin
			limit_q <= name_limit;
		end
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			phase_q    <= PH_HEADER;
			skip_q     <= '0;
			shift_q    <= '0;
			method_q   <= '0;
			packed_q   <= '0;
			unpacked_q <= '0;
			nlen_q     <= '0;
			offset_q   <= '0;
			extra_q    <= '0;
			hash_q     <= FNV_BASIS;
			hash_en_q  <= 1'b0;
			stopped_q  <= 1'b0;
		end else if (acc) begin
			pos_q      <= pos_d;
			phase_q    <= phase_d;
			skip_q     <= skip_d;
			shift_q    <= shift_d;
			method_q   <= method_d;
			packed_q   <= packed_d;
			unpacked_q <= unpacked_d;
			nlen_q     <= nlen_d;
			offset_q   <= offset_d;
			extra_q    <= extra_d;
			hash_q     <= hash_d;
			hash_en_q  <= hash_en_d;
			stopped_q  <= stopped_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload; only entry records carry fields
	always_ff @(posedge clk) begin
		if (acc && emit) begin
			out_kind_q <= kind;
			if (done) begin
				out_method_q   <= method_d;
				out_packed_q   <= packed_d;
				out_unpacked_q <= unpacked_d;
				out_nlen_q     <= nlen_d;
				out_offset_q   <= offset_d;
				out_digest_q   <= rec_hashed ? hash_d : 64'd0;
				out_hashed_q   <= rec_hashed;
			end else begin
				out_method_q   <= '0;
				out_packed_q   <= '0;
				out_unpacked_q <= '0;
				out_nlen_q     <= '0;
				out_offset_q   <= '0;
				out_digest_q   <= '0;
				out_hashed_q   <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign record_kind   = out_kind_q;
	assign method        = out_method_q;
	assign packed_size   = out_packed_q;
	assign unpacked_size = out_unpacked_q;
	assign name_bytes    = out_nlen_q;
	assign header_offset = out_offset_q;
	assign name_digest   = out_digest_q;
	assign name_hashed   = out_hashed_q;

	// A stopped directory never produces a record
	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && stopped_q) |-> !emit)
		else $error("record emitted while directory stopped");

	// Stream end always returns to a clean header phase
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && stream_end) |=> (!stopped_q && phase_q == PH_HEADER && pos_q == '0))
		else $error("parse state not cleared after stream end");

	// Header position is idle outside the header phase
	a_pos_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEADER) |-> (pos_q == '0))
		else $error("header position nonzero outside header phase");

	// Header position stays within the fixed header
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (pos_q <= POS_LAST))
		else $error("header position beyond header length");

	// Non-entry records carry no digest
	a_plain_record: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q != KIND_ENTRY) |-> (out_digest_q == 64'd0 && !out_hashed_q))
		else $error("end or truncation record carries a digest");

endmodule
